// ===== rtl/core/mffh_pkg.sv =====
// Shared types, constants and the CRC byte step for the fixed frame hunter.
// Used by every module in rtl/core; depends on nothing else.
package mffh_pkg;

  localparam int FRAME_LEN = 8;
  localparam int CRC_BYTES = 6;
  localparam int FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] REG_LO_MATCH      = 8'h08;
  localparam logic [7:0] FORCED_ADDRESS    = 8'h01;
  localparam logic [7:0] ADDRESS_RESET     = 8'h01;

  // Byte 0 sits in the lowest bits.
  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  typedef struct packed {
    logic   push;
    frame_t frame;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_rd_t;

  // One byte of the reflected Modbus CRC, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/mffh_front.sv =====
// Front end: holds the address register and the byte window, and queues candidate frames.
// Depends on mffh_pkg.
module mffh_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // data_byte[7:0]
  input  logic [0:0]           s_tuser,   // buffer_start[0]
  input  logic                 q_full,
  output mffh_pkg::q_wr_t      q_wr
);
  import mffh_pkg::*;

  logic [7:0]        slave_address;
  frame_t            window;
  frame_t            window_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              accept;
  logic              start;
  frame_t            cand;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign start    = s_tuser[0];

  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      window_next[i] = start ? 8'h00 : window[i+1];
    end
    window_next[FRAME_LEN-1] = s_tdata;
    if (start) begin
      fill_next = FILL_W'(1);
    end else if (fill < FILL_W'(FRAME_LEN)) begin
      fill_next = fill + FILL_W'(1);
    end else begin
      fill_next = fill;
    end
  end

  // A write-single request to register low byte 0x08 is taken as broadcast to address 1.
  always_comb begin
    cand = window_next;
    if (window_next[1] == FUNC_WRITE_SINGLE && window_next[3] == REG_LO_MATCH) begin
      cand[0] = FORCED_ADDRESS;
    end
  end

  assign q_wr.push  = accept && fill_next == FILL_W'(FRAME_LEN)
                      && window_next[0] == slave_address;
  assign q_wr.frame = cand;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= ADDRESS_RESET;
      window        <= '0;
      fill          <= '0;
    end else begin
      if (cfg_we) begin
        slave_address <= cfg_data;
      end
      if (accept) begin
        window <= window_next;
        fill   <= fill_next;
      end
    end
  end

endmodule

// ===== rtl/core/mffh_queue.sv =====
// Short candidate queue between the front end and the CRC pipeline.
// Depends on mffh_pkg.
module mffh_queue (
  input  logic            clk,
  input  logic            rst,
  input  mffh_pkg::q_wr_t wr,
  output logic            full,
  output mffh_pkg::q_rd_t rd,
  input  logic            rd_ready
);
  import mffh_pkg::*;

  frame_t          entries [QDEPTH];
  logic [QAW-1:0]  wptr;
  logic [QAW-1:0]  rptr;
  logic [QAW:0]    count;
  logic            pop;

  assign full     = count == (QAW+1)'(QDEPTH);
  assign rd.valid = count != '0;
  assign rd.frame = entries[rptr];
  assign pop      = rd.valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      unique case ({wr.push, pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      entries[wptr] <= wr.frame;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr.push) else $error("push into a full candidate queue");

endmodule

// ===== rtl/core/mffh_back.sv =====
// Back end: CRC pipeline, one frame byte per stage, then match check and output register.
// Depends on mffh_pkg.
module mffh_back (
  input  logic            clk,
  input  logic            rst,
  input  mffh_pkg::q_rd_t q_rd,
  output logic            q_ready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [63:0]     m_tdata    // frame_b0[7:0] .. frame_b7[63:56], b0 lowest
);
  import mffh_pkg::*;

  logic [CRC_BYTES-1:0] vld;
  logic [CRC_BYTES-1:0] free;
  frame_t               frm [CRC_BYTES];
  logic [15:0]          crc [CRC_BYTES];
  logic                 match;
  logic                 out_free;
  logic                 out_vld;
  frame_t               out_frame;

  assign out_free = !out_vld || m_tready;
  assign match    = crc[CRC_BYTES-1] == {frm[CRC_BYTES-1][7], frm[CRC_BYTES-1][6]};

  // A stage can take new data when empty or when its content moves on; a failing
  // frame in the last stage is simply dropped.
  always_comb begin
    free[CRC_BYTES-1] = !vld[CRC_BYTES-1] || !match || out_free;
    for (int k = CRC_BYTES - 2; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
  end

  assign q_ready  = free[0];
  assign m_tvalid = out_vld;
  assign m_tdata  = out_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      if (free[0]) begin
        vld[0] <= q_rd.valid;
      end
      for (int k = 1; k < CRC_BYTES; k++) begin
        if (free[k]) begin
          vld[k] <= vld[k-1];
        end
      end
      if (out_free) begin
        out_vld <= vld[CRC_BYTES-1] && match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) begin
      frm[0] <= q_rd.frame;
      crc[0] <= crc_byte(CRC_INIT, q_rd.frame[0]);
    end
    for (int k = 1; k < CRC_BYTES; k++) begin
      if (free[k]) begin
        frm[k] <= frm[k-1];
        crc[k] <= crc_byte(crc[k-1], frm[k-1][k]);
      end
    end
    if (out_free) begin
      out_frame <= frm[CRC_BYTES-1];
    end
  end

  a_pop_fills_stage0: assert property (@(posedge clk) disable iff (rst)
    q_rd.valid && q_ready |=> vld[0]) else $error("popped frame lost before stage 0");

  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    vld[CRC_BYTES-1] && match && !out_free |=> vld[CRC_BYTES-1]
    && $stable(frm[CRC_BYTES-1])) else $error("matching frame lost while output stalled");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_vld && !m_tready |=> out_vld && $stable(out_frame))
    else $error("output frame changed while stalled");

  a_out_crc_ok: assert property (@(posedge clk) disable iff (rst)
    !out_vld && vld[CRC_BYTES-1] && !match |=> !out_vld)
    else $error("frame with bad CRC reached the output");

endmodule

// ===== rtl/core/modbus_fixed_frame_hunter.sv =====
// Top level of the fixed-length Modbus RTU frame hunter.
// Instantiates mffh_front, mffh_queue and mffh_back; depends on mffh_pkg.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tdata = data_byte, s_tuser = buffer_start
//   m_*     | out | m_tvalid/m_tready  | m_tdata = frame_b0..frame_b7, b0 lowest
//   cfg_*   | in  | cfg_we             | cfg_data = slave_address
//
// One byte is accepted per cycle; s_tready drops only while the 4-entry candidate queue is full.
// A matching frame goes from the queue write into stage 0, on through the six CRC stages, and then
// into the output register, which raises m_tvalid.
// rst is synchronous: window, fill count and queue clear, slave_address returns to 1.
// A stalled m_tready backs up the CRC stages and then the queue; the window keeps running
// until the queue fills.
module modbus_fixed_frame_hunter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // data_byte[7:0]
  input  logic [0:0]  s_tuser,    // buffer_start[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata     // frame_b0[7:0], frame_b1[15:8], ... frame_b7[63:56]
);
  import mffh_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_ready;

  mffh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  mffh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .full     (q_full),
    .rd       (q_rd),
    .rd_ready (q_ready)
  );

  mffh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_rd     (q_rd),
    .q_ready  (q_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== test/tb_modbus_fixed_frame_hunter.sv =====
// Self-checking testbench for the fixed-length Modbus RTU frame hunter.
// Depends on mffh_pkg and modbus_fixed_frame_hunter; streams bytes, predicts frames, checks them.
`timescale 1ns / 100ps

module tb_modbus_fixed_frame_hunter;
  import mffh_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_TICKS = 16;

  // Tracks the hunter's window and holds the frames it must still deliver.
  class frame_ledger;
    logic [7:0] slave_addr;
    frame_t     window;
    int         fill;
    frame_t     awaited_frames[$];
    int         errors;

    function new();
      slave_addr = ADDRESS_RESET;
      window     = '0;
      fill       = 0;
      errors     = 0;
    endfunction

    static function logic [15:0] crc16_of(frame_t f);
      logic [15:0] c;
      logic        fb;
      c = CRC_INIT;
      // Bit-serial form of the reflected CRC, LSB of each byte first.
      for (int i = 0; i < CRC_BYTES * 8; i++) begin
        fb = c[0] ^ f[i / 8][i % 8];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    static function frame_t candidate_of(frame_t f);
      if (f[1] == FUNC_WRITE_SINGLE && f[3] == REG_LO_MATCH) begin
        f[0] = FORCED_ADDRESS;
      end
      return f;
    endfunction

    function void take_byte(logic [7:0] d, logic st);
      frame_t      cand;
      logic [15:0] c;
      if (st) begin
        window = '0;
        fill   = 0;
      end
      window = {d, window[FRAME_LEN-1:1]};
      if (fill < FRAME_LEN) begin
        fill++;
      end
      if (fill == FRAME_LEN && window[0] == slave_addr) begin
        cand = candidate_of(window);
        c    = crc16_of(cand);
        if (c == {cand[7], cand[6]}) begin
          awaited_frames.push_back(cand);
        end
      end
    endfunction

    function void match_frame(frame_t got);
      frame_t want;
      if (awaited_frames.size() == 0) begin
        $error("frame with no request waiting for it: %h", got);
        errors++;
        return;
      end
      want = awaited_frames.pop_front();
      for (int i = 0; i < FRAME_LEN; i++) begin
        if (want[i] !== got[i]) begin
          $error("frame_b%0d: expected %02h, actual %02h", i, want[i], got[i]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return awaited_frames.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        cfg_we   = 1'b0;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic [0:0]  s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  frame_ledger ledger = new();

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   sent_count    = 0;
  int   cycle_count   = 0;
  int   hold_token    = 0;
  int   token_seen    = 0;
  int   hold_left     = 0;
  logic force_start   = 1'b0;

  modbus_fixed_frame_hunter i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off each time hold_token moves.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (token_seen != hold_token) begin
      token_seen <= hold_token;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      ledger.take_byte(s_tdata, s_tuser[0]);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      ledger.match_frame(m_tdata);
    end
  end

  function automatic frame_t seal_frame(frame_t f);
    logic [15:0] c;
    c    = frame_ledger::crc16_of(frame_ledger::candidate_of(f));
    f[6] = c[7:0];
    f[7] = c[15:8];
    return f;
  endfunction

  function automatic frame_t random_frame(logic [7:0] addr, logic forced);
    frame_t f;
    f    = {$urandom, $urandom};
    f[0] = addr;
    if (forced || $urandom_range(99) < 20) begin
      f[1] = FUNC_WRITE_SINGLE;
      f[3] = REG_LO_MATCH;
    end
    return seal_frame(f);
  endfunction

  // A valid frame whose CRC high byte equals the address, so a second frame can start on it.
  function automatic frame_t overlapping_frame(logic [7:0] addr, logic forced);
    frame_t f;
    f = random_frame(addr, forced);
    while (f[7] != addr) begin
      f[4] = 8'($urandom);
      f[5] = 8'($urandom);
      f    = seal_frame(f);
    end
    return f;
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= st;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    sent_count++;
  endtask

  task automatic send_frame(input frame_t f, input int first, input int last,
                            input logic st);
    for (int i = first; i <= last; i++) begin
      send_byte(f[i], (i == first) ? st : 1'b0);
    end
  endtask

  task automatic drain_frames();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_address(input logic [7:0] addr);
    drain_frames();
    repeat (SETTLE_TICKS) @(posedge clk);
    cfg_data <= addr;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we            <= 1'b0;
    ledger.slave_addr = addr;
  endtask

  task automatic send_unit();
    int          pick;
    int          n;
    frame_t      f;
    frame_t      g;
    logic [7:0]  addr;
    logic [63:0] flip;
    logic        st;
    pick        = $urandom_range(99);
    addr        = ledger.slave_addr;
    st          = force_start || ($urandom_range(99) < 30);
    force_start = 1'b0;
    if (pick < 55) begin
      send_frame(random_frame(addr, 1'b0), 0, FRAME_LEN - 1, st);
    end else if (pick < 62) begin
      f = random_frame(addr ^ 8'($urandom_range(1, 255)), 1'b0);
      send_frame(f, 0, FRAME_LEN - 1, st);
    end else if (pick < 72) begin
      n    = $urandom_range(8, 63);
      flip = 64'd1 << n;
      f    = random_frame(addr, 1'b0) ^ flip;
      send_frame(f, 0, FRAME_LEN - 1, st);
    end else if (pick < 82) begin
      // A new buffer cuts this frame short.
      send_frame(random_frame(addr, 1'b0), 0, $urandom_range(0, 6), st);
      force_start = 1'b1;
    end else if (pick < 87) begin
      f = overlapping_frame(addr, 1'($urandom_range(1)));
      g = random_frame(addr, 1'b0);
      send_frame(f, 0, FRAME_LEN - 1, st);
      send_frame(g, 1, FRAME_LEN - 1, 1'b0);
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        send_byte(8'($urandom), $urandom_range(99) < 10);
      end
    end
  endtask

  task automatic run_phase(input int target);
    while (sent_count < target) begin
      send_unit();
    end
  endtask

  initial begin
    frame_t f;
    frame_t g;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: partial window, a clean frame, then a forced-address frame whose CRC
    // high byte starts a second, overlapping frame.
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(FUNC_WRITE_SINGLE, 1'b0);
    send_byte(REG_LO_MATCH, 1'b0);
    send_frame(random_frame(ADDRESS_RESET, 1'b0), 0, FRAME_LEN - 1, 1'b1);
    f = overlapping_frame(ADDRESS_RESET, 1'b1);
    g = random_frame(ADDRESS_RESET, 1'b0);
    send_frame(f, 0, FRAME_LEN - 1, 1'b0);
    send_frame(g, 1, FRAME_LEN - 1, 1'b0);

    write_address(8'h00);
    send_idle_pct = 25;
    recv_idle_pct = 48;
    run_phase(470);

    write_address(8'hFF);
    send_idle_pct = 48;
    recv_idle_pct = 25;
    run_phase(910);

    write_address(8'($urandom_range(2, 254)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Long receiver hold-off while frames keep coming, so the queue fills.
    hold_token <= hold_token + 1;
    repeat (32) begin
      send_frame(random_frame(ledger.slave_addr, 1'b0), 0, FRAME_LEN - 1, 1'b0);
    end
    drain_frames();
    run_phase(1350);

    drain_frames();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (ledger.pending() != 0) begin
      $error("%0d expected frames never arrived", ledger.pending());
      ledger.errors++;
    end
    if (ledger.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mffh_pkg.sv
rtl/core/mffh_front.sv
rtl/core/mffh_queue.sv
rtl/core/mffh_back.sv
rtl/core/modbus_fixed_frame_hunter.sv
test/tb_modbus_fixed_frame_hunter.sv
